// ===== rtl/windowed_rate_meter_limiter_defines.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef WINDOWED_RATE_METER_LIMITER_DEFINES_SVH
`define WINDOWED_RATE_METER_LIMITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define WRLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define WRLM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define WRLM_ASSERT(label, prop, msg)
`define WRLM_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/wrlm_pkg.sv =====
package wrlm_pkg;

  localparam int DATA_W  = 32;
  localparam int CHUNK_W = 31;

  localparam logic [DATA_W-1:0] BYTE_LIMIT_RESET = 32'd1048576;

  localparam logic OP_ACCOUNT = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] sec;
    logic [DATA_W-1:0] bytes;
  } slot_t;

endpackage

// ===== rtl/windowed_rate_meter_limiter.sv =====
// Channel   Handshake                  Carries
// input     start, busy                op, now_sec, byte_count, request_bytes
// result    done (one-cycle strobe)    speed, speed_updated, chunk_allowed, must_wait
// config    cfg_valid, cfg_ready       byte_limit_per_second
//
// A query, or an account item within the current second, gives its result in the
// cycle after the transfer, and the next item may follow at once.
// An account item that starts a new second rotates the row of window cells once
// and then multiplies by the reciprocal of the window length, one part at a time:
// the strobe follows the rotation and the multiply, with busy high until then.
// Reset clears the window and counters and sets the limit to BYTE_LIMIT_RESET.
// Results cannot be stalled; the receiver must take each strobe.
`include "windowed_rate_meter_limiter_defines.svh"

module windowed_rate_meter_limiter #(
  parameter int WINDOW_SECONDS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [wrlm_pkg::DATA_W-1:0]         now_sec,
  input  logic [wrlm_pkg::CHUNK_W-1:0]        byte_count,
  input  logic [wrlm_pkg::CHUNK_W-1:0]        request_bytes,
  output logic                                done,
  output logic [wrlm_pkg::DATA_W-1:0]         speed,
  output logic                                speed_updated,
  output logic [wrlm_pkg::CHUNK_W-1:0]        chunk_allowed,
  output logic                                must_wait,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wrlm_pkg::DATA_W-1:0]         byte_limit_per_second
);

  localparam int W     = wrlm_pkg::DATA_W;
  localparam int CW    = wrlm_pkg::CHUNK_W;
  localparam int SUM_W = W + $clog2(WINDOW_SECONDS);
  localparam int CNT_W = $clog2(WINDOW_SECONDS);

  typedef enum logic [1:0] {IDLE, SUM, DIV} state_t;

  state_t state;

  logic [W-1:0]     limit;
  logic [W-1:0]     current_second;
  logic [W-1:0]     bytes_this_second;
  logic [W-1:0]     speed_reg;
  logic [W-1:0]     lower;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] acc_next;
  logic [CNT_W-1:0] cnt;

  wrlm_pkg::slot_t feed;
  wrlm_pkg::slot_t chain [WINDOW_SECONDS];
  logic [W-1:0]    tail_hit;
  logic            shift;

  logic            accept;
  logic            same_sec;
  logic            roll_accept;
  logic [W:0]      acc_sum;
  logic [W-1:0]    used;
  logic [W:0]      room;
  logic            wait_now;
  logic [CW-1:0]   chunk_now;

  logic            div_start;
  logic            div_valid;
  logic [SUM_W-1:0] quotient;

  assign busy        = (state != IDLE);
  assign cfg_ready   = (state == IDLE);
  assign accept      = start && !busy;
  assign same_sec    = (now_sec == current_second);
  assign roll_accept = accept && (op == wrlm_pkg::OP_ACCOUNT) && !same_sec;

  assign acc_sum   = {1'b0, bytes_this_second} + (W+1)'(byte_count);
  assign used      = same_sec ? bytes_this_second : '0;
  assign room      = {1'b0, limit} - {1'b0, used};
  assign wait_now  = room[W] || (room[W-1:0] == '0);
  assign chunk_now = wait_now ? '0 :
                     ((W'(request_bytes) < room[W-1:0]) ? request_bytes : room[CW-1:0]);

  assign shift = roll_accept || (state == SUM);
  assign feed  = (state == SUM) ? chain[WINDOW_SECONDS-1]
                                : wrlm_pkg::slot_t'{sec: current_second,
                                                    bytes: bytes_this_second};

  generate
    for (genvar i = 0; i < WINDOW_SECONDS; i++) begin : g_cell
      if (i == WINDOW_SECONDS - 1) begin : g_tail
        wrlm_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift     (shift),
          .slot_in   (chain[i-1]),
          .lower     (lower),
          .slot_out  (chain[i]),
          .bytes_hit (tail_hit)
        );
      end else if (i == 0) begin : g_head
        wrlm_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift     (shift),
          .slot_in   (feed),
          .lower     (lower),
          .slot_out  (chain[i]),
          .bytes_hit ()
        );
      end else begin : g_mid
        wrlm_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift     (shift),
          .slot_in   (chain[i-1]),
          .lower     (lower),
          .slot_out  (chain[i]),
          .bytes_hit ()
        );
      end
    end
  endgenerate

  assign acc_next  = acc + SUM_W'(tail_hit);
  assign div_start = (state == SUM) && (cnt == CNT_W'(WINDOW_SECONDS - 1));

  wrlm_div #(
    .DIVISOR    (WINDOW_SECONDS),
    .DIVIDEND_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_next),
    .valid    (div_valid),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= IDLE;
      limit             <= wrlm_pkg::BYTE_LIMIT_RESET;
      current_second    <= '0;
      bytes_this_second <= '0;
      speed_reg         <= '0;
      done              <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        limit <= byte_limit_per_second;
      end
      case (state)
        IDLE: begin
          if (roll_accept) begin
            current_second    <= now_sec;
            bytes_this_second <= W'(byte_count);
            lower             <= now_sec - W'(WINDOW_SECONDS);
            acc               <= '0;
            cnt               <= '0;
            state             <= SUM;
          end else if (accept) begin
            done          <= 1'b1;
            speed         <= speed_reg;
            speed_updated <= 1'b0;
            if (op == wrlm_pkg::OP_ACCOUNT) begin
              bytes_this_second <= acc_sum[W] ? '1 : acc_sum[W-1:0];
              chunk_allowed     <= '0;
              must_wait         <= 1'b0;
            end else begin
              chunk_allowed <= chunk_now;
              must_wait     <= wait_now;
            end
          end
        end
        SUM: begin
          acc <= acc_next;
          cnt <= cnt + CNT_W'(1);
          if (div_start) begin
            state <= DIV;
          end
        end
        DIV: begin
          if (div_valid) begin
            speed_reg     <= quotient[W-1:0];
            speed         <= quotient[W-1:0];
            speed_updated <= 1'b1;
            chunk_allowed <= '0;
            must_wait     <= 1'b0;
            done          <= 1'b1;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `WRLM_NEVER(a_done_while_busy, done && busy, "result strobe while busy")
  `WRLM_ASSERT(a_roll_goes_busy, roll_accept |=> busy, "new second did not start rotation")
  `WRLM_ASSERT(a_plain_item_done, (accept && !roll_accept) |=> done,
               "item within the second gave no result")
  `WRLM_NEVER(a_wait_with_chunk, done && must_wait && (chunk_allowed != '0),
              "allowance given while waiting")
  `WRLM_NEVER(a_update_on_query, done && speed_updated && must_wait,
              "speed update flagged on a query result")

endmodule

// ===== rtl/wrlm_cell.sv =====
// One slot of the window. It takes its neighbor's slot on every shift and
// reports its byte count when its second, compared signed, is not below lower.
module wrlm_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              shift,
  input  wrlm_pkg::slot_t                   slot_in,
  input  logic [wrlm_pkg::DATA_W-1:0]       lower,
  output wrlm_pkg::slot_t                   slot_out,
  output logic [wrlm_pkg::DATA_W-1:0]       bytes_hit
);

  wrlm_pkg::slot_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= slot_in;
    end
  end

  assign slot_out  = slot;
  assign bytes_hit = ($signed(slot.sec) >= $signed(lower)) ? slot.bytes : '0;

endmodule

// ===== rtl/wrlm_div.sv =====
// Divides by a fixed constant by multiplying with its rounded-up reciprocal,
// sixteen reciprocal bits per cycle, most significant part first.
module wrlm_div #(
  parameter int DIVISOR    = 16,
  parameter int DIVIDEND_W = 36
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic                  valid,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int PART_W  = 16;
  localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int PARTS   = (DIVIDEND_W + PART_W) / PART_W;
  localparam int RECIP_W = PARTS * PART_W;
  localparam int PROD_W  = DIVIDEND_W + RECIP_W;
  localparam int MUL_W   = DIVIDEND_W + PART_W;
  localparam int CNT_W   = $clog2(PARTS + 1);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

  logic [DIVIDEND_W-1:0] num;
  logic [RECIP_W-1:0]    recip;
  logic [MUL_W-1:0]      part_prod;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     prod_next;
  logic [CNT_W-1:0]      count;

  assign part_prod = {{PART_W{1'b0}}, num} *
                     {{DIVIDEND_W{1'b0}}, recip[RECIP_W-1 -: PART_W]};
  assign prod_next = {prod[PROD_W-PART_W-1:0], {PART_W{1'b0}}} + PROD_W'(part_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (start) begin
        count <= CNT_W'(PARTS);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= dividend;
      recip <= RECIP;
      prod  <= '0;
    end else if (count != '0) begin
      prod  <= prod_next;
      recip <= {recip[RECIP_W-PART_W-1:0], {PART_W{1'b0}}};
    end
  end

  assign quotient = DIVIDEND_W'(prod >> SHIFT);

endmodule

// ===== dv/windowed_rate_meter_limiter_checker.sv =====
module windowed_rate_meter_limiter_checker #(
  parameter int WINDOW_SECONDS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         op,
  input  logic [wrlm_pkg::DATA_W-1:0]  now_sec,
  input  logic [wrlm_pkg::CHUNK_W-1:0] byte_count,
  input  logic [wrlm_pkg::CHUNK_W-1:0] request_bytes,
  input  logic                         done,
  input  logic [wrlm_pkg::DATA_W-1:0]  speed,
  input  logic                         speed_updated,
  input  logic [wrlm_pkg::CHUNK_W-1:0] chunk_allowed,
  input  logic                         must_wait,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [wrlm_pkg::DATA_W-1:0]  byte_limit_per_second,
  output int                           mismatch_count,
  output int                           reports_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import wrlm_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]  speed;
    logic               speed_updated;
    logic [CHUNK_W-1:0] chunk_allowed;
    logic               must_wait;
  } meter_report_t;

  logic [DATA_W-1:0] ring_sec [WINDOW_SECONDS];
  logic [DATA_W-1:0] ring_bytes [WINDOW_SECONDS];
  int                ring_next;
  logic [DATA_W-1:0] counted_sec;
  logic [DATA_W-1:0] counted_bytes;
  logic [DATA_W-1:0] avg_speed;
  logic [DATA_W-1:0] limit_held;
  meter_report_t     meter_reports_q [$];

  initial begin
    mismatch_count = 0;
    reports_outstanding = 0;
  end

  task automatic meter_update(input logic item_op, input logic [DATA_W-1:0] t,
                              input logic [CHUNK_W-1:0] amount,
                              input logic [CHUNK_W-1:0] wanted,
                              output meter_report_t rep);
    logic [DATA_W:0]   grown;
    logic [63:0]       total;
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] used;
    logic [DATA_W-1:0] room;
    rep = '0;
    if (item_op == OP_ACCOUNT) begin
      if (t == counted_sec) begin
        grown = {1'b0, counted_bytes} + {2'b00, amount};
        counted_bytes = grown[DATA_W] ? '1 : grown[DATA_W-1:0];
      end else begin
        ring_sec[ring_next] = counted_sec;
        ring_bytes[ring_next] = counted_bytes;
        ring_next = (ring_next + 1) % WINDOW_SECONDS;
        counted_sec = t;
        counted_bytes = {1'b0, amount};
        lower = t - DATA_W'(WINDOW_SECONDS);
        total = '0;
        for (int i = 0; i < WINDOW_SECONDS; i++) begin
          if ($signed(ring_sec[i]) >= $signed(lower)) total += ring_bytes[i];
        end
        total = total / WINDOW_SECONDS;
        avg_speed = (total > 64'hFFFF_FFFF) ? '1 : total[DATA_W-1:0];
        rep.speed_updated = 1'b1;
      end
    end else begin
      used = (t == counted_sec) ? counted_bytes : '0;
      if (used >= limit_held) begin
        rep.must_wait = 1'b1;
      end else begin
        room = limit_held - used;
        rep.chunk_allowed = ({1'b0, wanted} < room) ? wanted : room[CHUNK_W-1:0];
      end
    end
    rep.speed = avg_speed;
  endtask

  always @(posedge clk) begin
    meter_report_t got;
    meter_report_t want;
    if (rst) begin
      for (int i = 0; i < WINDOW_SECONDS; i++) begin
        ring_sec[i] = '0;
        ring_bytes[i] = '0;
      end
      ring_next = 0;
      counted_sec = '0;
      counted_bytes = '0;
      avg_speed = '0;
      limit_held = BYTE_LIMIT_RESET;
      meter_reports_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit_held = byte_limit_per_second;
      if (done) begin
        got = '{speed, speed_updated, chunk_allowed, must_wait};
        if (meter_reports_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no transfer waiting: speed=%h upd=%b chunk=%h wait=%b",
                     $time, got.speed, got.speed_updated, got.chunk_allowed, got.must_wait);
        end else begin
          want = meter_reports_q.pop_front();
          if (got.speed !== want.speed || got.speed_updated !== want.speed_updated ||
              got.chunk_allowed !== want.chunk_allowed || got.must_wait !== want.must_wait) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected %h %b %h %b, got %h %b %h %b", $time,
                       want.speed, want.speed_updated, want.chunk_allowed, want.must_wait,
                       got.speed, got.speed_updated, got.chunk_allowed, got.must_wait);
          end
        end
      end
      if (start && !busy) begin
        meter_update(op, now_sec, byte_count, request_bytes, want);
        meter_reports_q.push_back(want);
      end
    end
    reports_outstanding = meter_reports_q.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wrlm_pkg::*;

  localparam int WINDOW       = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES       = 6;
  localparam logic [CHUNK_W-1:0] MAX31 = '1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               op = OP_ACCOUNT;
  logic [DATA_W-1:0]  now_sec = '0;
  logic [CHUNK_W-1:0] byte_count = '0;
  logic [CHUNK_W-1:0] request_bytes = '0;
  logic               done;
  logic [DATA_W-1:0]  speed;
  logic               speed_updated;
  logic [CHUNK_W-1:0] chunk_allowed;
  logic               must_wait;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DATA_W-1:0]  byte_limit_per_second = '0;
  int                 mismatch_count;
  int                 reports_outstanding;
  int                 cycle_count = 0;
  logic [DATA_W-1:0]  limit_now = BYTE_LIMIT_RESET;
  bit                 gaps_on = 1'b1;

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  windowed_rate_meter_limiter #(.WINDOW_SECONDS(WINDOW)) DUT (.*);

  windowed_rate_meter_limiter_checker #(.WINDOW_SECONDS(WINDOW)) meter_checker (.*);

  task automatic send_item(input logic item_op, input logic [DATA_W-1:0] item_sec,
                           input logic [CHUNK_W-1:0] item_bytes,
                           input logic [CHUNK_W-1:0] item_req);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    op <= item_op;
    now_sec <= item_sec;
    byte_count <= item_bytes;
    request_bytes <= item_req;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (reports_outstanding != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [DATA_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    byte_limit_per_second <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_now = value;
  endtask

  function automatic logic [CHUNK_W-1:0] pick_amount(input logic [DATA_W-1:0] span);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return CHUNK_W'($urandom_range(0, span));
      6, 7:             return CHUNK_W'($urandom);
      8:                return '0;
      default:          return MAX31;
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] item_sec;
    logic              item_op;
    case ($urandom_range(0, 3))
      0:       t = $urandom_range(0, 1000);
      1:       t = 32'h7FFF_FFF0 + $urandom_range(0, 8);
      2:       t = 32'hFFFF_FFF0 + $urandom_range(0, 8);
      default: t = $urandom;
    endcase
    span = limit_now >> 1;
    if (span > {1'b0, MAX31}) span = {1'b0, MAX31};
    if (span == '0) span = 1;
    for (int n = 0; n < count; n++) begin
      item_op = ($urandom_range(0, 9) < 4) ? OP_QUERY : OP_ACCOUNT;
      item_sec = t;
      if (item_op == OP_ACCOUNT) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: ;
          6, 7:             t = t + 1;
          8:                t = t + $urandom_range(2, 20);
          default:          t = $urandom_range(0, 1) ? t - $urandom_range(1, 20) : $urandom;
        endcase
        item_sec = t;
      end else if ($urandom_range(0, 4) == 0) begin
        item_sec = $urandom_range(0, 1) ? t - 1 : t + $urandom_range(1, 3);
      end
      send_item(item_op, item_sec, pick_amount(span), pick_amount(span << 1));
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(OP_QUERY, 32'd0, '0, '0);
    send_item(OP_QUERY, 32'd0, '0, MAX31);
    send_item(OP_ACCOUNT, 32'd0, MAX31, '0);
    send_item(OP_ACCOUNT, 32'd0, MAX31, '0);
    send_item(OP_ACCOUNT, 32'd0, MAX31, '0);
    send_item(OP_QUERY, 32'd0, '0, 31'd5);
    send_item(OP_QUERY, 32'd1, '0, MAX31);
    send_item(OP_ACCOUNT, 32'd1, 31'd100, MAX31);
    send_item(OP_ACCOUNT, 32'hFFFF_FFFF, MAX31, '0);
    send_item(OP_ACCOUNT, 32'h7FFF_FFFF, 31'd7, '0);
    send_item(OP_ACCOUNT, 32'h8000_0000, '0, '0);
    send_item(OP_QUERY, 32'h8000_0000, MAX31, 31'h12345);

    write_limit(32'd1);
    send_item(OP_QUERY, 32'h8000_0000, '0, '0);
    send_item(OP_QUERY, 32'h8000_0000, '0, MAX31);
    send_item(OP_ACCOUNT, 32'h8000_0000, 31'd1, '0);
    send_item(OP_QUERY, 32'h8000_0000, '0, MAX31);

    // A zero limit holds every query off, stale second or not.
    write_limit(32'd0);
    send_item(OP_QUERY, 32'h8000_0000, '0, 31'd3);
    send_item(OP_QUERY, 32'd5, '0, 31'd3);

    write_limit(32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'd5, '0, MAX31);
    send_item(OP_ACCOUNT, 32'h8000_0001, MAX31, '0);
    send_item(OP_QUERY, 32'h8000_0001, '0, MAX31);
    send_item(OP_ACCOUNT, 32'h8000_0001, MAX31, '0);
    send_item(OP_ACCOUNT, 32'h8000_0001, MAX31, '0);
    send_item(OP_QUERY, 32'h8000_0001, '0, 31'd1);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 6))
        0:       write_limit(32'd1);
        1:       write_limit(32'hFFFF_FFFF);
        2:       write_limit(BYTE_LIMIT_RESET);
        3, 4:    write_limit($urandom_range(1000, 5000000));
        5:       write_limit($urandom);
        default: write_limit($urandom_range(1, 200));
      endcase
      gaps_on = (p < PHASES - 1);
      random_phase(RANDOM_ITEMS / PHASES);
    end

    start <= 1'b0;
    while (reports_outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && reports_outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
